FILE: hw/rtl/setseq_pkg.sv
// Package for the sound effect tone sequencer: codes, field widths and the
// fixed effect tables with their precomputed timer settings.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package setseq_pkg;

  // Field widths of the two channels and the register port.
  localparam int unsigned PSC_W    = 8;
  localparam int unsigned RELOAD_W = 13;
  localparam int unsigned CMP_W    = 12;
  localparam int unsigned EFF_W    = 3;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned MS_W     = 8;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Operation codes.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  // Effect identifiers.
  localparam logic [EFF_W-1:0] EFFECT_NONE = 3'd0;
  localparam logic [EFF_W-1:0] EFFECT_FIRE = 3'd1;
  localparam logic [EFF_W-1:0] EFFECT_TX   = 3'd2;
  localparam logic [EFF_W-1:0] EFFECT_RX   = 3'd3;
  localparam logic [EFF_W-1:0] EFFECT_HIT  = 3'd4;
  localparam logic [EFF_W-1:0] EFFECT_WIN  = 3'd5;
  localparam logic [EFF_W-1:0] EFFECT_LOSE = 3'd6;

  // Register indexes on the configuration port.
  localparam logic REG_TIMER_CLOCK = 1'b0;

  // Reset values.
  localparam logic [PSC_W-1:0]    TIMER_CLOCK_RST = 8'd216;
  localparam logic [RELOAD_W-1:0] RELOAD_RST      = 13'd999;

  // One step of an effect with its tone already turned into timer values:
  // reload = 1000000 / f - 1 and compare = (reload + 1) / 2.
  typedef struct packed {
    logic                tone_on;
    logic [RELOAD_W-1:0] reload;
    logic [CMP_W-1:0]    compare;
    logic [MS_W-1:0]     dur_ms;
  } step_entry_t;

  // Number of steps in an effect; zero marks an unknown id.
  function automatic logic [STEP_W-1:0] seq_len(input logic [EFF_W-1:0] eff);
    logic [STEP_W-1:0] len;
    case (eff)
      EFFECT_FIRE, EFFECT_TX, EFFECT_RX: len = 2'd1;
      EFFECT_HIT, EFFECT_WIN:            len = 2'd3;
      EFFECT_LOSE:                       len = 2'd2;
      default:                           len = 2'd0;
    endcase
    return len;
  endfunction

  // Step table: tone settings and duration for each effect and step.
  function automatic step_entry_t step_lut(input logic [EFF_W-1:0] eff,
                                           input logic [STEP_W-1:0] step);
    step_entry_t e;
    e = '{tone_on: 1'b0, reload: '0, compare: '0, dur_ms: '0};
    case (eff)
      EFFECT_FIRE: if (step == 2'd0) e = '{1'b1, 13'd554, 12'd277, 8'd60};
      EFFECT_TX:   if (step == 2'd0) e = '{1'b1, 13'd832, 12'd416, 8'd20};
      EFFECT_RX:   if (step == 2'd0) e = '{1'b1, 13'd1110, 12'd555, 8'd20};
      EFFECT_HIT: begin
        case (step)
          2'd0:    e = '{1'b1, 13'd2856, 12'd1428, 8'd120};
          2'd1:    e = '{1'b0, 13'd0, 12'd0, 8'd40};
          2'd2:    e = '{1'b1, 13'd3999, 12'd2000, 8'd140};
          default: e = '{1'b0, 13'd0, 12'd0, 8'd0};
        endcase
      end
      EFFECT_WIN: begin
        case (step)
          2'd0:    e = '{1'b1, 13'd1110, 12'd555, 8'd80};
          2'd1:    e = '{1'b1, 13'd713, 12'd357, 8'd80};
          2'd2:    e = '{1'b1, 13'd499, 12'd250, 8'd140};
          default: e = '{1'b0, 13'd0, 12'd0, 8'd0};
        endcase
      end
      EFFECT_LOSE: begin
        case (step)
          2'd0:    e = '{1'b1, 13'd3332, 12'd1666, 8'd180};
          2'd1:    e = '{1'b1, 13'd4999, 12'd2500, 8'd220};
          default: e = '{1'b0, 13'd0, 12'd0, 8'd0};
        endcase
      end
      default: e = '{1'b0, 13'd0, 12'd0, 8'd0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/setseq_if.sv
// Valid/ready channel interfaces of the tone sequencer: command beats in,
// timer setting beats out. Depends on setseq_pkg for the field widths.
`default_nettype none

interface setseq_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [setseq_pkg::EFF_W-1:0]   effect_id;
  logic                           force_req;

  modport source (output valid, output operation, output effect_id,
                  output force_req, input ready);
  modport sink   (input valid, input operation, input effect_id,
                  input force_req, output ready);
endinterface

interface setseq_tone_if;
  logic                              valid;
  logic                              ready;
  logic [setseq_pkg::PSC_W-1:0]      prescaler;
  logic [setseq_pkg::RELOAD_W-1:0]   reload;
  logic [setseq_pkg::CMP_W-1:0]      compare;
  logic                              playing;

  modport source (output valid, output prescaler, output reload,
                  output compare, output playing, input ready);
  modport sink   (input valid, input prescaler, input reload,
                  input compare, input playing, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sound_effect_tone_sequencer_top.sv
// Top level of the sound effect tone sequencer: step state, timer settings
// and the result register. Depends on setseq_pkg and setseq_if.sv.
//
//  Channel   Dir  Contents                                    Beat when
//  cmd_i     in   operation, effect_id, force_req             valid & ready
//  tone_o    out  prescaler, reload, compare, playing         valid & ready
//  APB       in   timer_clock_mhz at byte address 0           psel & penable
//
// A command beat is accepted in every cycle while the result register is empty or
// being drained, and its result is registered and appears in the next cycle. The
// result comes from the single result register behind the step logic. Reset
// clears the sequence state and loads reload 999 and a timer clock of 216 MHz.
// A stalled result holds cmd_i.ready low until it is taken.
`default_nettype none

module sound_effect_tone_sequencer_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  setseq_cmd_if.sink                        cmd_i,
  setseq_tone_if.source                     tone_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [setseq_pkg::PADDR_W-1:0]    paddr,
  input  wire  [setseq_pkg::PDATA_W-1:0]    pwdata,
  output logic [setseq_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);
  import setseq_pkg::*;

  // Configuration and sequence state.
  logic [PSC_W-1:0]    timer_clk_q;
  logic                active_q, active_d;
  logic [EFF_W-1:0]    effect_q, effect_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [MS_W-1:0]     remain_q, remain_d;
  logic [RELOAD_W-1:0] reload_q, reload_d;
  logic [CMP_W-1:0]    compare_q, compare_d;
  logic [PSC_W-1:0]    psc_q, psc_d;

  // Result register.
  logic                out_valid_q;
  logic [PSC_W-1:0]    out_psc_q;
  logic [RELOAD_W-1:0] out_reload_q;
  logic [CMP_W-1:0]    out_cmp_q;
  logic                out_play_q;

  logic                accept;
  logic                start;
  logic                trig;
  logic [PSC_W-1:0]    psc_new;
  logic [MS_W-1:0]     remain_dec;
  logic [STEP_W:0]     next_step;
  logic [EFF_W-1:0]    sel_eff;
  logic [STEP_W-1:0]   sel_step;
  logic                load_step;
  step_entry_t         entry;

  // Register port: one register, writes complete in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMER_CLOCK) ?
                  {{(PDATA_W-PSC_W){1'b0}}, timer_clk_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clk_q <= TIMER_CLOCK_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_TIMER_CLOCK) begin
      timer_clk_q <= pwdata[PSC_W-1:0];
    end
  end

  // The result register frees up when it is empty or drained this cycle.
  assign cmd_i.ready = !out_valid_q || tone_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // A clock of zero counts as one, giving a prescaler of zero.
  assign psc_new = (timer_clk_q == '0) ? '0 : timer_clk_q - 8'd1;

  assign trig       = (cmd_i.operation == OP_TRIGGER);
  assign start      = trig && (cmd_i.force_req || !active_q) &&
                      (seq_len(cmd_i.effect_id) != '0);
  assign remain_dec = (remain_q != '0) ? remain_q - 8'd1 : '0;
  assign next_step  = {1'b0, step_q} + 3'd1;

  // Pick the step that begins on this beat, if any.
  always_comb begin
    sel_eff   = effect_q;
    sel_step  = next_step[STEP_W-1:0];
    load_step = 1'b0;
    if (start) begin
      sel_eff   = cmd_i.effect_id;
      sel_step  = '0;
      load_step = 1'b1;
    end else if (!trig && active_q && remain_dec == '0 &&
                 next_step < {1'b0, seq_len(effect_q)}) begin
      load_step = 1'b1;
    end
  end

  assign entry = step_lut(sel_eff, sel_step);

  // Next sequence state for the beat being accepted.
  always_comb begin
    active_d  = active_q;
    effect_d  = effect_q;
    step_d    = step_q;
    remain_d  = remain_q;
    reload_d  = reload_q;
    compare_d = compare_q;
    psc_d     = psc_q;
    if (start) begin
      active_d = 1'b1;
      effect_d = cmd_i.effect_id;
      step_d   = '0;
    end else if (!trig && active_q) begin
      remain_d = remain_dec;
      if (remain_dec == '0) begin
        if (load_step) begin
          step_d = next_step[STEP_W-1:0];
        end else begin
          // Last step done: go silent.
          active_d  = 1'b0;
          step_d    = '0;
          compare_d = '0;
        end
      end
    end
    if (load_step) begin
      remain_d = entry.dur_ms;
      if (entry.tone_on) begin
        psc_d     = psc_new;
        reload_d  = entry.reload;
        compare_d = entry.compare;
      end else begin
        compare_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      effect_q  <= EFFECT_NONE;
      step_q    <= '0;
      remain_q  <= '0;
      reload_q  <= RELOAD_RST;
      compare_q <= '0;
      psc_q     <= '0;
    end else if (accept) begin
      active_q  <= active_d;
      effect_q  <= effect_d;
      step_q    <= step_d;
      remain_q  <= remain_d;
      reload_q  <= reload_d;
      compare_q <= compare_d;
      psc_q     <= psc_d;
    end
  end

  // Result register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (tone_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_psc_q    <= psc_d;
      out_reload_q <= reload_d;
      out_cmp_q    <= compare_d;
      out_play_q   <= active_d;
    end
  end

  assign tone_o.valid     = out_valid_q;
  assign tone_o.prescaler = out_psc_q;
  assign tone_o.reload    = out_reload_q;
  assign tone_o.compare   = out_cmp_q;
  assign tone_o.playing   = out_play_q;

  // Silence whenever no effect is playing.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> compare_q == '0)
    else $error("compare is nonzero while idle");

  // The step index stays inside the running effect.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> step_q < seq_len(effect_q))
    else $error("step index beyond effect length");

  // An unknown effect never starts a sequence from idle.
  a_unknown_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !active_q && trig && seq_len(cmd_i.effect_id) == '0) |=> !active_q)
    else $error("unknown effect started a sequence");

endmodule

`default_nettype wire

FILE: test/tone_setting_checker.sv
`timescale 1ns / 100ps
// Checker for the sound effect tone sequencer: follows command beats and register
// writes, predicts every timer setting beat and compares it. Uses setseq_pkg, setseq_if.sv.

module tone_setting_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  setseq_cmd_if                          cmd_i,
  setseq_tone_if                         tone_i,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire                            pready,
  input  wire  [setseq_pkg::PADDR_W-1:0] paddr,
  input  wire  [setseq_pkg::PDATA_W-1:0] pwdata,
  input  wire  [setseq_pkg::PDATA_W-1:0] prdata,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import setseq_pkg::*;

  localparam int unsigned US_PER_SEC = 1000000;
  localparam logic [PADDR_W-1:0] TIMER_CLOCK_ADDR = PADDR_W'(4 * int'(REG_TIMER_CLOCK));

  typedef struct packed {
    logic [PSC_W-1:0]    prescaler;
    logic [RELOAD_W-1:0] reload;
    logic [CMP_W-1:0]    compare;
    logic                playing;
  } tone_beat_t;

  // Timer settings still owed by the block, oldest first.
  tone_beat_t expected_tones[$];
  tone_beat_t got_beat;
  tone_beat_t want_beat;

  // Predicted state of the sequencer and its timer registers.
  logic [PSC_W-1:0]    timer_mhz;
  logic                active_q;
  logic [EFF_W-1:0]    effect_q;
  logic [STEP_W-1:0]   step_q;
  logic [MS_W-1:0]     remain_q;
  logic [RELOAD_W-1:0] reload_q;
  logic [CMP_W-1:0]    cmp_q;
  logic [PSC_W-1:0]    psc_q;
  int unsigned         shown;

  // Number of steps in each effect; unknown ids have none.
  function automatic logic [STEP_W-1:0] effect_steps(input logic [EFF_W-1:0] eff);
    case (eff)
      EFFECT_FIRE, EFFECT_TX, EFFECT_RX: return 2'd1;
      EFFECT_HIT, EFFECT_WIN:            return 2'd3;
      EFFECT_LOSE:                       return 2'd2;
      default:                           return 2'd0;
    endcase
  endfunction

  // Tone of one step in Hz; zero is a silent step.
  function automatic int unsigned step_freq(input logic [EFF_W-1:0] eff,
                                            input logic [STEP_W-1:0] step);
    int unsigned hz;
    hz = 0;
    case (eff)
      EFFECT_FIRE: if (step == 2'd0) hz = 1800;
      EFFECT_TX:   if (step == 2'd0) hz = 1200;
      EFFECT_RX:   if (step == 2'd0) hz = 900;
      EFFECT_HIT:  hz = (step == 2'd0) ? 350 : (step == 2'd2) ? 250 : 0;
      EFFECT_WIN:  hz = (step == 2'd0) ? 900 : (step == 2'd1) ? 1400 :
                        (step == 2'd2) ? 2000 : 0;
      EFFECT_LOSE: hz = (step == 2'd0) ? 300 : (step == 2'd1) ? 200 : 0;
      default:     hz = 0;
    endcase
    return hz;
  endfunction

  // Duration of one step in milliseconds.
  function automatic logic [MS_W-1:0] step_ms(input logic [EFF_W-1:0] eff,
                                              input logic [STEP_W-1:0] step);
    logic [MS_W-1:0] ms;
    ms = '0;
    case (eff)
      EFFECT_FIRE: if (step == 2'd0) ms = 8'd60;
      EFFECT_TX:   if (step == 2'd0) ms = 8'd20;
      EFFECT_RX:   if (step == 2'd0) ms = 8'd20;
      EFFECT_HIT:  ms = (step == 2'd0) ? 8'd120 : (step == 2'd1) ? 8'd40 :
                        (step == 2'd2) ? 8'd140 : 8'd0;
      EFFECT_WIN:  ms = (step == 2'd0) ? 8'd80 : (step == 2'd1) ? 8'd80 :
                        (step == 2'd2) ? 8'd140 : 8'd0;
      EFFECT_LOSE: ms = (step == 2'd0) ? 8'd180 : (step == 2'd1) ? 8'd220 : 8'd0;
      default:     ms = '0;
    endcase
    return ms;
  endfunction

  // Loads the timer registers for the current step and restarts its duration.
  task automatic start_step();
    int unsigned hz;
    int unsigned mhz;
    int unsigned period;
    hz = step_freq(effect_q, step_q);
    if (hz == 0) begin
      // A silent step only mutes the output.
      cmp_q = '0;
    end else begin
      // A zero timer clock is taken as 1 MHz.
      mhz = (timer_mhz == '0) ? 1 : int'(timer_mhz);
      psc_q = PSC_W'(mhz - 1);
      period = US_PER_SEC / hz;
      if (period < 2) period = 2;
      period = period - 1;
      reload_q = RELOAD_W'(period);
      cmp_q = CMP_W'((period + 1) / 2);
    end
    remain_q = step_ms(effect_q, step_q);
  endtask

  // Applies one command beat and queues the settings it leaves behind.
  task automatic advance_sequencer(input logic op, input logic [EFF_W-1:0] eff,
                                   input logic frc);
    if (op == OP_TRIGGER) begin
      // A busy trigger without force and an unknown effect change nothing.
      if ((frc || !active_q) && effect_steps(eff) != 2'd0) begin
        effect_q = eff;
        step_q = '0;
        active_q = 1'b1;
        start_step();
      end
    end else if (active_q) begin
      if (remain_q != '0) remain_q = remain_q - 1'b1;
      if (remain_q == '0) begin
        step_q = step_q + 1'b1;
        if (step_q >= effect_steps(effect_q)) begin
          active_q = 1'b0;
          step_q = '0;
          cmp_q = '0;
        end else begin
          start_step();
        end
      end
    end
    expected_tones.push_back('{psc_q, reload_q, cmp_q, active_q});
  endtask

  // Watch the register port and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_mhz = TIMER_CLOCK_RST;
      active_q = 1'b0;
      effect_q = EFFECT_NONE;
      step_q = '0;
      remain_q = '0;
      reload_q = RELOAD_RST;
      cmp_q = '0;
      psc_q = '0;
      expected_tones.delete();
      shown = 0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // Register writes update the timer clock; reads must return it.
      if (psel && penable && pready && paddr == TIMER_CLOCK_ADDR) begin
        if (pwrite) begin
          timer_mhz = pwdata[PSC_W-1:0];
        end else if (prdata !== PDATA_W'(timer_mhz)) begin
          fail_count_o++;
          if (shown < 10) begin
            shown++;
            $display("%0t: timer clock read: expected %0d, got %0d", $realtime,
                     timer_mhz, prdata);
          end
        end
      end

      // Compare the result beat before queueing the new command's result.
      if (tone_i.valid && tone_i.ready) begin
        got_beat = '{tone_i.prescaler, tone_i.reload, tone_i.compare, tone_i.playing};
        if (expected_tones.size() == 0) begin
          fail_count_o++;
          if (shown < 10) begin
            shown++;
            $display("%0t: unexpected beat psc %0d reload %0d cmp %0d playing %0b",
                     $realtime, got_beat.prescaler, got_beat.reload,
                     got_beat.compare, got_beat.playing);
          end
        end else begin
          want_beat = expected_tones.pop_front();
          if (got_beat !== want_beat) begin
            fail_count_o++;
            if (shown < 10) begin
              shown++;
              $display("%0t: expected psc %0d reload %0d cmp %0d playing %0b",
                       $realtime, want_beat.prescaler, want_beat.reload,
                       want_beat.compare, want_beat.playing);
              $display("%0t:      got psc %0d reload %0d cmp %0d playing %0b",
                       $realtime, got_beat.prescaler, got_beat.reload,
                       got_beat.compare, got_beat.playing);
            end
          end
        end
      end

      if (cmd_i.valid && cmd_i.ready) begin
        advance_sequencer(cmd_i.operation, cmd_i.effect_id, cmd_i.force_req);
      end
      pending_o = expected_tones.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Top of the tone sequencer testbench: clock, reset, command and register stimulus,
// result stalls and the verdict. Uses setseq_pkg, setseq_if.sv and tone_setting_checker.

module testbench;
  import setseq_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 390;
  localparam logic [EFF_W-1:0]   EFFECT_UNUSED    = 3'd7;
  localparam logic [PADDR_W-1:0] TIMER_CLOCK_ADDR = PADDR_W'(4 * int'(REG_TIMER_CLOCK));

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;

  setseq_cmd_if  cmd_ch ();
  setseq_tone_if tone_ch ();

  sound_effect_tone_sequencer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_ch),
    .tone_o  (tone_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tone_setting_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_ch),
    .tone_i       (tone_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 2 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The result side stalls in random bursts while idling is allowed.
  initial begin
    tone_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        tone_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      tone_ch.ready = 1'b1;
    end
  end

  // Total length of an effect in milliseconds.
  function automatic int unsigned effect_total_ms(input logic [EFF_W-1:0] eff);
    case (eff)
      EFFECT_FIRE:          return 60;
      EFFECT_TX, EFFECT_RX: return 20;
      EFFECT_HIT:           return 300;
      EFFECT_WIN:           return 300;
      EFFECT_LOSE:          return 400;
      default:              return 0;
    endcase
  endfunction

  // Presents one command beat, called and returning at a falling edge.
  task automatic send_cmd(input logic op, input logic [EFF_W-1:0] eff, input logic frc);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    cmd_ch.valid     = 1'b1;
    cmd_ch.operation = op;
    cmd_ch.effect_id = eff;
    cmd_ch.force_req = frc;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // A tick whose unused fields carry random bits.
  task automatic send_tick();
    send_cmd(OP_TICK, EFF_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // Stops the command side and waits until every result has been taken.
  task automatic drain_channel();
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes the timer clock while the block is idle, then reads it back.
  task automatic write_timer_clock(input logic [PDATA_W-1:0] value);
    drain_channel();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = TIMER_CLOCK_ADDR;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Edge cases: idle tick, unknown ids, busy and forced triggers, step expiry.
  task automatic run_directed();
    send_cmd(OP_TICK, EFFECT_NONE, 1'b0);
    send_cmd(OP_TRIGGER, EFFECT_NONE, 1'b0);
    send_cmd(OP_TRIGGER, EFFECT_UNUSED, 1'b1);
    send_cmd(OP_TRIGGER, EFFECT_TX, 1'b0);
    send_cmd(OP_TRIGGER, EFFECT_FIRE, 1'b0);
    send_cmd(OP_TRIGGER, EFFECT_UNUSED, 1'b1);
    send_cmd(OP_TRIGGER, EFFECT_RX, 1'b1);
    repeat (20) send_cmd(OP_TICK, EFFECT_UNUSED, 1'b1);
    send_cmd(OP_TICK, EFFECT_NONE, 1'b0);
  endtask

  // Triggers one effect and ticks through it, mostly to its end, with stray triggers.
  // The ticks stop early once the phase has sent its share of beats.
  task automatic play_effect(input int unsigned stop_at);
    logic [EFF_W-1:0] eff;
    int unsigned      total;
    int unsigned      ticks;
    if ($urandom_range(0, 1) == 0) eff = EFF_W'($urandom_range(1, 3));
    else eff = EFF_W'($urandom_range(4, 6));
    total = effect_total_ms(eff);
    send_cmd(OP_TRIGGER, eff, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) != 0) ticks = total + $urandom_range(0, 3);
    else ticks = $urandom_range(1, total);
    repeat (ticks) begin
      if (items_sent >= stop_at) break;
      if ($urandom_range(0, 49) == 0) begin
        send_cmd(OP_TRIGGER, EFF_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
      send_tick();
    end
  endtask

  // One random phase of well-formed effects mixed with bursts of noise.
  task automatic run_random(input int unsigned count, input bit allow_idle);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        play_effect(stop_at);
      end else begin
        repeat ($urandom_range(4, 16)) begin
          if (items_sent >= stop_at) break;
          if ($urandom_range(0, 1) == 0) send_tick();
          else send_cmd(OP_TRIGGER, EFF_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_TICK;
    cmd_ch.effect_id = EFFECT_NONE;
    cmd_ch.force_req = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset timer clock first, then the extremes and a random value.
    run_directed();
    write_timer_clock(PDATA_W'(255));
    run_random(ITEMS_PER_PHASE, 1'b1);
    write_timer_clock(PDATA_W'(1));
    run_random(ITEMS_PER_PHASE, 1'b1);
    write_timer_clock(PDATA_W'(0));
    run_random(ITEMS_PER_PHASE, 1'b1);
    write_timer_clock(($urandom() & 32'hFFFF_FF00) | PDATA_W'($urandom_range(2, 254)));
    run_random(ITEMS_PER_PHASE, 1'b1);

    // Last phase runs back to back, with junk in the unused write bits.
    write_timer_clock(($urandom() & 32'hFFFF_FF00) | PDATA_W'(TIMER_CLOCK_RST));
    idle_on = 1'b0;
    run_random(ITEMS_PER_PHASE, 1'b0);

    drain_channel();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/setseq_pkg.sv
hw/rtl/setseq_if.sv
hw/rtl/sound_effect_tone_sequencer_top.sv
test/tone_setting_checker.sv
test/testbench.sv
